### src/krt_pkg.sv
// Package with types and constants shared by the keyed record table.
`default_nettype none
package krt_pkg;
  localparam int ENTRIES_DEFAULT = 16;
  localparam int REC_W = 32 + 160 + 80 + 160;

  localparam logic [2:0] KIND_ADD = 3'd0;
  localparam logic [2:0] KIND_GET = 3'd1;
  localparam logic [2:0] KIND_DEL = 3'd2;
  localparam logic [2:0] KIND_MOD = 3'd3;
  localparam logic [2:0] KIND_SORT = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_DUP = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic [2:0] kind;
    logic signed [31:0] key;
    logic [63:0] name_high;
    logic [63:0] name_middle;
    logic [31:0] name_tail;
    logic [63:0] phone_high;
    logic [15:0] phone_tail;
    logic [63:0] addr_high;
    logic [63:0] addr_middle;
    logic [31:0] addr_tail;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] entries_held;
    logic signed [31:0] found_key;
    logic [63:0] found_name_high;
    logic [63:0] found_name_middle;
    logic [31:0] found_name_tail;
    logic [63:0] found_phone_high;
    logic [15:0] found_phone_tail;
    logic [63:0] found_addr_high;
    logic [63:0] found_addr_middle;
    logic [31:0] found_addr_tail;
  } rsp_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic [159:0] name;
    logic [79:0] phone;
    logic [159:0] addr;
  } rec_t;

  // Operation that every cell applies.
  typedef enum logic [2:0] {
    OP_HOLD, OP_ROTATE, OP_WRITE, OP_SHIFT_DOWN, OP_SORT_STEP
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic [8:0] count;
  } cell_ctl_t;
endpackage
`default_nettype wire

### src/keyed_record_table.sv
// Top level of the keyed record table: a chain of record cells and its sequencer.
//
// Requests enter on req (valid req_valid, stall req_stall); one response per
// request leaves on rsp (rsp_valid, rsp_stall). The table is a row of ENTRIES
// cells. Searches rotate the row one place per cycle and compare the record at
// cell 0, so add, get, delete and modify scan every held entry, then act in
// S_FINISH and answer from S_OUT. A full scan returns the row to its place.
// Delete rotates past the match, then shifts the later cells down once.
// Sort does one compare-exchange per cycle between two cursor cells, over
// every pair of held cells, and then answers from S_OUT.
// Unknown kinds and sorts of at most one entry go straight to S_OUT.
// One request is worked on at a time; req_stall is high until the response is
// loaded, and the next request is taken in the following cycle. While
// rsp_stall holds a response, one more request may be taken and worked on,
// and it then waits to be loaded. The response register holds its value while
// rsp_stall is high. Reset empties the table and drops any pending response.
`default_nettype none
module keyed_record_table
  import krt_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic req_stall,
  input  wire req_t req,
  output logic rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t rsp
);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_ALIGN, S_FINISH, S_SORT, S_OUT} state_t;

  state_t state;
  req_t cur;
  logic [8:0] count;
  logic [8:0] steps;
  logic [8:0] pos;
  logic found;
  logic [IW-1:0] si, sj;
  rec_t found_rec;
  cell_ctl_t ctl;
  rec_t recs [ENTRIES];
  rec_t in_rec;
  logic [8:0] n;
  logic [1:0] out_status;

  assign in_rec = '{key: cur.key,
                    name: {cur.name_high, cur.name_middle, cur.name_tail},
                    phone: {cur.phone_high, cur.phone_tail},
                    addr: {cur.addr_high, cur.addr_middle, cur.addr_tail}};
  assign req_stall = (state != S_IDLE);

  // Sort compares cell i with cell j directly, without rotating the row.
  logic sort_swap;
  assign sort_swap = recs[si].name > recs[sj].name;

  always_comb begin
    out_status = ST_OK;
    if (cur.kind == KIND_ADD) begin
      if (steps == 9'h1ff) begin
        out_status = ST_FULL;
      end else if (found) begin
        out_status = ST_DUP;
      end
    end else if (cur.kind == KIND_GET || cur.kind == KIND_DEL || cur.kind == KIND_MOD) begin
      if (!found) out_status = ST_MISSING;
    end
  end

  always_comb begin
    ctl.count = count;
    ctl.op = OP_HOLD;
    unique case (state)
      S_SCAN: ctl.op = OP_ROTATE;
      S_ALIGN: ctl.op = (steps != 9'd0) ? OP_ROTATE : OP_HOLD;
      S_FINISH: begin
        priority if (cur.kind == KIND_ADD && !found && count < 9'(ENTRIES)) begin
          ctl.op = OP_WRITE;
        end else if (cur.kind == KIND_MOD && found) begin
          ctl.op = OP_WRITE;
        end else if (cur.kind == KIND_DEL && found) begin
          ctl.op = OP_SHIFT_DOWN;
        end else begin
          ctl.op = OP_HOLD;
        end
      end
      S_SORT: ctl.op = sort_swap ? OP_SORT_STEP : OP_HOLD;
      default: ctl.op = OP_HOLD;
    endcase
  end

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      rec_t above, below;
      logic wsel, ssel, lo, hi;
      if (g + 1 < ENTRIES) begin : g_a
        assign above = recs[g+1];
      end else begin : g_na
        assign above = recs[g];
      end
      assign below = recs[0];
      assign wsel = (cur.kind == KIND_ADD) ? (9'(g) == count) : (9'(g) == pos);
      assign ssel = (9'(g) >= pos) && (9'(g) + 9'd1 < count);
      assign lo = (IW'(g) == si);
      assign hi = (IW'(g) == sj);
      krt_cell #(.INDEX(g)) u_cell (
        .clk(clk), .ctl(ctl), .write_rec(in_rec), .write_sel(wsel),
        .from_above(lo ? recs[sj] : above),
        .from_below(hi ? recs[si] : below),
        .shift_sel(ssel), .sort_lower(lo), .sort_upper(hi),
        .rec(recs[g]));
    end
  endgenerate

  assign n = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      rsp_valid <= 1'b0;
      found <= 1'b0;
      steps <= '0;
      pos <= '0;
      si <= '0;
      sj <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur <= req;
            found <= 1'b0;
            steps <= '0;
            pos <= '0;
            found_rec <= '0;
            si <= '0;
            sj <= IW'(1);
            priority if (req.kind == KIND_SORT) begin
              state <= (n > 9'd1) ? S_SORT : S_OUT;
            end else if (req.kind == KIND_ADD || req.kind == KIND_GET ||
                         req.kind == KIND_DEL || req.kind == KIND_MOD) begin
              state <= (n == 9'd0) ? S_FINISH : S_SCAN;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_SCAN: begin
          if (!found && recs[0].key == cur.key) begin
            found <= 1'b1;
            pos <= steps;
            found_rec <= recs[0];
          end
          steps <= steps + 9'd1;
          if (steps + 9'd1 == count) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (cur.kind == KIND_ADD && !found && count < 9'(ENTRIES)) begin
            count <= count + 9'd1;
          end else if (cur.kind == KIND_DEL && found) begin
            count <= count - 9'd1;
          end
          state <= S_OUT;
        end
        S_SORT: begin
          if (32'(sj) + 1 < 32'(count)) begin
            sj <= sj + IW'(1);
          end else if (32'(si) + 2 < 32'(count)) begin
            si <= si + IW'(1);
            sj <= si + IW'(2);
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid <= 1'b1;
            rsp.entries_held <= count[4:0];
            rsp.status <= out_status;
            {rsp.found_key, rsp.found_name_high, rsp.found_name_middle,
             rsp.found_name_tail, rsp.found_phone_high, rsp.found_phone_tail,
             rsp.found_addr_high, rsp.found_addr_middle, rsp.found_addr_tail} <=
              (cur.kind == KIND_GET && found) ? found_rec : '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_FINISH && cur.kind == KIND_ADD && count >= 9'(ENTRIES)) begin
        steps <= 9'h1ff;
      end
      if (rsp_valid && !rsp_stall && state != S_OUT) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 9'(ENTRIES))
    else $error("entry count beyond table size");
  assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> req_stall)
    else $error("request taken while busy");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SORT) |-> (si < sj))
    else $error("sort cursors out of order");
endmodule
`default_nettype wire

### src/krt_cell.sv
// One table cell: holds one record and trades it with the cell above, with cell 0, or with the other sort cursor cell.
`default_nettype none
module krt_cell
  import krt_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  wire logic clk,
  input  wire cell_ctl_t ctl,
  input  wire rec_t write_rec,
  input  wire logic write_sel,
  input  wire rec_t from_above,
  input  wire rec_t from_below,
  input  wire logic shift_sel,
  input  wire logic sort_lower,
  input  wire logic sort_upper,
  output rec_t rec
);
  logic [8:0] idx;
  assign idx = 9'(INDEX);

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_HOLD: rec <= rec;
      OP_ROTATE: begin
        if (idx + 9'd1 < ctl.count) begin
          rec <= from_above;
        end else if (idx + 9'd1 == ctl.count) begin
          rec <= from_below;
        end
      end
      OP_WRITE: if (write_sel) rec <= write_rec;
      OP_SHIFT_DOWN: if (shift_sel) rec <= from_above;
      OP_SORT_STEP: begin
        if (sort_lower) begin
          rec <= from_above;
        end else if (sort_upper) begin
          rec <= from_below;
        end
      end
      default: rec <= rec;
    endcase
  end
endmodule
`default_nettype wire
